/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/ffpa_pkg.sv */
// Types, constants and codes of the first-fit pool allocator.
package ffpa_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_SEGMENTS = 64;
    localparam int MAX_BLOCKS   = 128;

    // Pool offsets, including the end of the pool
    localparam int AW    = $clog2(POOL_BYTES + 1);
    // Arithmetic width for sums and compares
    localparam int CW    = ((AW > 12) ? AW : 12) + 2;
    localparam int SI_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int RI_W  = $clog2(MAX_BLOCKS);
    localparam int RC_W  = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic        req_type;
        logic [11:0] alloc_size;
        logic [11:0] free_addr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] data_addr;
    } rsp_t;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [AW-1:0] len;
    } seg_t;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [AW-1:0] size;
    } rec_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_SRD,
        S_A_SCHK,
        S_A_RSCAN,
        S_F_RRD,
        S_F_RCHK,
        S_F_SRD,
        S_F_SCHK,
        S_F_DEC,
        S_SHL_RD,
        S_SHL_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_SEG_RD,
        OP_IDX_INC,
        OP_CUR,
        OP_PREV,
        OP_RIDX_INC,
        OP_A_APPLY,
        OP_REC_RD,
        OP_F_HIT,
        OP_MERGE,
        OP_K_RD_UP,
        OP_K_WR_UP,
        OP_K_RD_DN,
        OP_K_WR_DN,
        OP_CNT_DEC,
        OP_PUT,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_err;
        status_t err;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_end;
        logic fit;
        logic rec_end;
        logic rec_used;
        logic addr_match;
        logic start_ge;
        logic join_prev;
        logic join_next;
        logic seg_full;
        logic rem_big;
        logic up_more;
        logic dn_more;
        logic rsp_free;
    } dp_stat_t;

endpackage

/* rtl/core/ffpa_dp.sv */
// Datapath: segment and record tables, scan counters, merge arithmetic, result register.
module ffpa_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ffpa_pkg::req_t    req,
    input  ffpa_pkg::dp_cmd_t cmd,
    output ffpa_pkg::dp_stat_t stat,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ffpa_pkg::rsp_t    rsp
);
    import ffpa_pkg::*;

    localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);

    // Tables
    seg_t seg_mem [MAX_SEGMENTS];
    rec_t rec_mem [MAX_BLOCKS];

    seg_t             seg_rd_reg;
    rec_t             rec_rd_reg;
    req_t             req_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] k_reg;
    logic [RC_W-1:0]  ridx_reg;
    seg_t             cur_reg;
    seg_t             prev_reg;
    logic [AW-1:0]    flen_reg;
    logic [RI_W-1:0]  rsel_reg;
    logic [MAX_BLOCKS-1:0] rec_valid_reg;
    status_t          res_code_reg;
    logic [11:0]      res_addr_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic [CW-1:0]    need;
    logic [CW-1:0]    fstart;
    logic [CW-1:0]    rem;
    logic [CW-1:0]    prev_end;
    logic [CW-1:0]    free_end;
    logic [CW-1:0]    cur_data;
    logic             merge_ok;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] k_p1;
    logic [CNT_W-1:0] k_m1;
    logic             seg_we;
    logic [SI_W-1:0]  seg_wa;
    seg_t             seg_wd;
    logic             seg_re;
    logic [SI_W-1:0]  seg_ra;
    logic [CW-1:0]    merged_len;

    // Request arithmetic
    assign need     = CW'(req_reg.alloc_size) + HDR;
    assign fstart   = CW'(req_reg.free_addr) - HDR;
    assign rem      = CW'(cur_reg.len) - need;
    assign cur_data = CW'(cur_reg.start) + HDR;
    assign prev_end = CW'(prev_reg.start) + HDR + CW'(prev_reg.len);
    assign free_end = fstart + HDR + CW'(flen_reg);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign k_p1     = k_reg + CNT_W'(1);
    assign k_m1     = k_reg - CNT_W'(1);

    // Status to the controller
    always_comb
    begin
        stat.idx_end    = (idx_reg == cnt_reg);
        stat.fit        = (CW'(seg_rd_reg.len) >= need);
        stat.rec_end    = (ridx_reg == RC_W'(MAX_BLOCKS));
        stat.rec_used   = rec_valid_reg[ridx_reg[RI_W-1:0]];
        stat.addr_match = (CW'(rec_rd_reg.addr) == CW'(req_reg.free_addr));
        stat.start_ge   = (CW'(seg_rd_reg.start) >= fstart);
        stat.join_prev  = (idx_reg != '0) && (prev_end == fstart);
        stat.join_next  = (idx_reg != cnt_reg) && (free_end == CW'(cur_reg.start));
        stat.seg_full   = (cnt_reg == CNT_W'(MAX_SEGMENTS));
        stat.rem_big    = (rem > HDR);
        stat.up_more    = (k_p1 < cnt_reg);
        stat.dn_more    = (k_reg > idx_reg);
        stat.rsp_free   = !rsp_valid_reg || rsp_ready;
    end

    assign merge_ok = stat.join_prev || stat.join_next || !stat.seg_full;

    // Segment table port selection
    always_comb
    begin
        seg_we     = 1'b0;
        seg_wa     = idx_reg[SI_W-1:0];
        seg_wd     = seg_rd_reg;
        seg_re     = 1'b0;
        seg_ra     = idx_reg[SI_W-1:0];
        merged_len = CW'(prev_reg.len) + HDR + CW'(flen_reg);
        if (stat.join_next)
        begin
            merged_len = merged_len + HDR + CW'(cur_reg.len);
        end
        case (cmd.op)
            OP_INIT:
            begin
                seg_we       = 1'b1;
                seg_wa       = '0;
                seg_wd.start = '0;
                seg_wd.len   = AW'(POOL_BYTES - HEADER_BYTES);
            end
            OP_A_APPLY:
            begin
                seg_we       = stat.rem_big;
                seg_wd.start = AW'(CW'(cur_reg.start) + need);
                seg_wd.len   = AW'(rem);
            end
            OP_MERGE:
            begin
                if (stat.join_prev)
                begin
                    seg_we       = 1'b1;
                    seg_wa       = idx_m1[SI_W-1:0];
                    seg_wd.start = prev_reg.start;
                    seg_wd.len   = AW'(merged_len);
                end
                else if (stat.join_next)
                begin
                    seg_we       = 1'b1;
                    seg_wd.start = AW'(fstart);
                    seg_wd.len   = AW'(CW'(cur_reg.len) + HDR + CW'(flen_reg));
                end
            end
            OP_PUT:
            begin
                seg_we       = 1'b1;
                seg_wd.start = AW'(fstart);
                seg_wd.len   = flen_reg;
            end
            OP_K_WR_UP, OP_K_WR_DN:
            begin
                seg_we = 1'b1;
                seg_wa = k_reg[SI_W-1:0];
            end
            OP_SEG_RD:
            begin
                seg_re = 1'b1;
            end
            OP_K_RD_UP:
            begin
                seg_re = 1'b1;
                seg_ra = k_p1[SI_W-1:0];
            end
            OP_K_RD_DN:
            begin
                seg_re = 1'b1;
                seg_ra = k_m1[SI_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Segment table
    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_wa] <= seg_wd;
        end
        if (seg_re)
        begin
            seg_rd_reg <= seg_mem[seg_ra];
        end
    end

    // Record table
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_A_APPLY)
        begin
            rec_mem[ridx_reg[RI_W-1:0]] <= '{addr: AW'(cur_data),
                size: stat.rem_big ? AW'(req_reg.alloc_size) : cur_reg.len};
        end
        if (cmd.op == OP_REC_RD)
        begin
            rec_rd_reg <= rec_mem[ridx_reg[RI_W-1:0]];
        end
    end

    // Request working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:    req_reg  <= req;
            OP_CUR:     cur_reg  <= seg_rd_reg;
            OP_PREV:    prev_reg <= seg_rd_reg;
            OP_F_HIT:
            begin
                flen_reg <= rec_rd_reg.size;
                rsel_reg <= ridx_reg[RI_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Counters, valid bits, result code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= CNT_W'(1);
            k_reg         <= '0;
            ridx_reg      <= '0;
            rec_valid_reg <= '0;
            res_code_reg  <= ST_OK;
            res_addr_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    idx_reg      <= '0;
                    ridx_reg     <= '0;
                    res_code_reg <= ST_OK;
                    res_addr_reg <= '0;
                end
                OP_IDX_INC, OP_PREV:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                OP_RIDX_INC:
                begin
                    ridx_reg <= ridx_reg + RC_W'(1);
                end
                OP_A_APPLY:
                begin
                    rec_valid_reg[ridx_reg[RI_W-1:0]] <= 1'b1;
                    res_addr_reg <= cur_data[11:0];
                    k_reg        <= idx_reg;
                end
                OP_MERGE:
                begin
                    if (merge_ok)
                    begin
                        rec_valid_reg[rsel_reg] <= 1'b0;
                    end
                    k_reg <= (stat.join_prev && stat.join_next) ? idx_reg : cnt_reg;
                end
                OP_K_WR_UP:
                begin
                    k_reg <= k_p1;
                end
                OP_K_WR_DN:
                begin
                    k_reg <= k_m1;
                end
                OP_CNT_DEC:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                OP_PUT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
            if (cmd.set_err)
            begin
                res_code_reg <= cmd.err;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_RESULT)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RESULT)
        begin
            rsp_reg.status    <= res_code_reg;
            rsp_reg.data_addr <= res_addr_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/core/ffpa_ctrl.sv */
// Controller: sequences table scans, updates, shifts and the result transaction.
module ffpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_type,
    output logic               req_ready,
    input  ffpa_pkg::dp_stat_t stat,
    output ffpa_pkg::dp_cmd_t  cmd
);
    import ffpa_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:    state_next = S_IDLE;
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req_type ? S_F_RRD : S_A_SRD;
                end
            end
            S_A_SRD:   state_next = stat.idx_end ? S_DONE : S_A_SCHK;
            S_A_SCHK:  state_next = stat.fit ? S_A_RSCAN : S_A_SRD;
            S_A_RSCAN:
            begin
                if (stat.rec_end)
                begin
                    state_next = S_DONE;
                end
                else if (!stat.rec_used)
                begin
                    state_next = stat.rem_big ? S_DONE : S_SHL_RD;
                end
            end
            S_F_RRD:
            begin
                if (stat.rec_end)
                begin
                    state_next = S_DONE;
                end
                else if (stat.rec_used)
                begin
                    state_next = S_F_RCHK;
                end
            end
            S_F_RCHK:  state_next = stat.addr_match ? S_F_SRD : S_F_RRD;
            S_F_SRD:   state_next = stat.idx_end ? S_F_DEC : S_F_SCHK;
            S_F_SCHK:  state_next = stat.start_ge ? S_F_DEC : S_F_SRD;
            S_F_DEC:
            begin
                if (stat.join_prev && stat.join_next)
                begin
                    state_next = S_SHL_RD;
                end
                else if (stat.join_prev || stat.join_next || stat.seg_full)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHR_RD;
                end
            end
            S_SHL_RD:  state_next = stat.up_more ? S_SHL_WR : S_DONE;
            S_SHL_WR:  state_next = S_SHL_RD;
            S_SHR_RD:  state_next = stat.dn_more ? S_SHR_WR : S_DONE;
            S_SHR_WR:  state_next = S_SHR_RD;
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_INIT;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.set_err = 1'b0;
        cmd.err     = ST_OK;
        req_ready   = 1'b0;
        case (state_reg)
            S_INIT:    cmd.op = OP_INIT;
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_A_SRD:
            begin
                if (stat.idx_end)
                begin
                    cmd.set_err = 1'b1;
                    cmd.err     = ST_NOFIT;
                end
                else
                begin
                    cmd.op = OP_SEG_RD;
                end
            end
            S_A_SCHK:  cmd.op = stat.fit ? OP_CUR : OP_IDX_INC;
            S_A_RSCAN:
            begin
                if (stat.rec_end)
                begin
                    cmd.set_err = 1'b1;
                    cmd.err     = ST_FULL;
                end
                else
                begin
                    cmd.op = stat.rec_used ? OP_RIDX_INC : OP_A_APPLY;
                end
            end
            S_F_RRD:
            begin
                if (stat.rec_end)
                begin
                    cmd.set_err = 1'b1;
                    cmd.err     = ST_BADFREE;
                end
                else
                begin
                    cmd.op = stat.rec_used ? OP_REC_RD : OP_RIDX_INC;
                end
            end
            S_F_RCHK:  cmd.op = stat.addr_match ? OP_F_HIT : OP_RIDX_INC;
            S_F_SRD:
            begin
                if (!stat.idx_end)
                begin
                    cmd.op = OP_SEG_RD;
                end
            end
            S_F_SCHK:  cmd.op = stat.start_ge ? OP_CUR : OP_PREV;
            S_F_DEC:
            begin
                cmd.op = OP_MERGE;
                if (!stat.join_prev && !stat.join_next && stat.seg_full)
                begin
                    cmd.set_err = 1'b1;
                    cmd.err     = ST_FULL;
                end
            end
            S_SHL_RD:  cmd.op = stat.up_more ? OP_K_RD_UP : OP_CNT_DEC;
            S_SHL_WR:  cmd.op = OP_K_WR_UP;
            S_SHR_RD:  cmd.op = stat.dn_more ? OP_K_RD_DN : OP_PUT;
            S_SHR_WR:  cmd.op = OP_K_WR_DN;
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.op = OP_RESULT;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/core/first_fit_pool_allocator_core.sv */
// From request transaction to result valid: allocate scans the segment table, then the record
// slots, then shifts segments on a whole-segment take. Free scans the record slots, then the
// segments, decides the merge, then shifts segments on insert or removal. The result is then
// posted. One request at a time: the next can be taken in the cycle after the result is posted,
// even while it waits. Reset writes the initial segment.
module first_fit_pool_allocator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ffpa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ffpa_pkg::rsp_t rsp
);
    import ffpa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Control
    ffpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Tables and arithmetic
    ffpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* rtl/core/ffpa_checker.sv */
// Port-level checker for the allocator core, bound to first_fit_pool_allocator_core.
`include "assert_macros.svh"

module ffpa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input ffpa_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input ffpa_pkg::rsp_t rsp
);
    import ffpa_pkg::*;

    // Stalled result holds
    `ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_NXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp))
    // Failed requests report no address
    `ASSERT_IMP(a_err_addr, clk, rst_n, rsp_valid && rsp.status != ST_OK, rsp.data_addr == '0)
    // Busy right after a request transaction
    `ASSERT_NXT(a_busy, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

bind first_fit_pool_allocator_core ffpa_checker u_ffpa_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the first-fit pool allocator core.
`timescale 1ns / 1ps

module tb_top;
    import ffpa_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    first_fit_pool_allocator_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always #5 clk = ~clk;

    // Allocator shadow state
    int unsigned free_start [MAX_SEGMENTS];
    int unsigned free_len [MAX_SEGMENTS];
    int unsigned free_cnt;
    int unsigned blk_addr [MAX_BLOCKS];
    int unsigned blk_len [MAX_BLOCKS];
    bit blk_live [MAX_BLOCKS];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int unsigned handed_out[$];   // data addresses returned by ok allocations
    int errors = 0;
    int unsigned cycles = 0;
    bit idle_off = 0;         // stretch with no idling
    bit hold_rsp = 0;         // long receiver hold-off
    bit send_pause = 0;

    function automatic void pool_reset();
        foreach (blk_live[i]) blk_live[i] = 0;
        foreach (free_start[i])
        begin
            free_start[i] = 0;
            free_len[i] = 0;
        end
        free_len[0] = POOL_BYTES - HEADER_BYTES;
        free_cnt = 1;
    endfunction

    function automatic void seg_drop(int unsigned at);
        for (int unsigned k = at; k + 1 < free_cnt; k++)
        begin
            free_start[k] = free_start[k+1];
            free_len[k] = free_len[k+1];
        end
        free_cnt--;
    endfunction

    // Predict the response for one request and update the shadow pool
    function automatic rsp_t pool_predict(req_t r);
        rsp_t o;
        int unsigned i, b, p, base, rem, need, ln;
        bit jn, jp;
        o.status = ST_OK;
        o.data_addr = '0;
        if (r.req_type == 1'b0)
        begin
            need = r.alloc_size + HEADER_BYTES;
            for (i = 0; i < free_cnt; i++) if (free_len[i] >= need) break;
            if (i >= free_cnt) begin o.status = ST_NOFIT; return o; end
            for (b = 0; b < MAX_BLOCKS; b++) if (!blk_live[b]) break;
            if (b >= MAX_BLOCKS) begin o.status = ST_FULL; return o; end
            base = free_start[i];
            rem = free_len[i] - need;
            if (rem > HEADER_BYTES)
            begin
                free_start[i] = base + need;
                free_len[i] = rem;
                blk_len[b] = r.alloc_size;
            end
            else
            begin
                blk_len[b] = free_len[i];
                seg_drop(i);
            end
            blk_addr[b] = base + HEADER_BYTES;
            blk_live[b] = 1;
            o.data_addr = 12'(base + HEADER_BYTES);
            return o;
        end
        for (b = 0; b < MAX_BLOCKS; b++)
            if (blk_live[b] && blk_addr[b] == r.free_addr) break;
        if (b >= MAX_BLOCKS) begin o.status = ST_BADFREE; return o; end
        base = r.free_addr - HEADER_BYTES;
        ln = blk_len[b];
        for (p = 0; p < free_cnt; p++) if (free_start[p] >= base) break;
        jn = p < free_cnt && base + HEADER_BYTES + ln == free_start[p];
        jp = p > 0 && free_start[p-1] + HEADER_BYTES + free_len[p-1] == base;
        if (jp && jn)
        begin
            free_len[p-1] += 2 * HEADER_BYTES + ln + free_len[p];
            seg_drop(p);
        end
        else if (jp)
            free_len[p-1] += HEADER_BYTES + ln;
        else if (jn)
        begin
            free_len[p] += HEADER_BYTES + ln;
            free_start[p] = base;
        end
        else
        begin
            if (free_cnt >= MAX_SEGMENTS) begin o.status = ST_FULL; return o; end
            for (int unsigned k = free_cnt; k > p; k--)
            begin
                free_start[k] = free_start[k-1];
                free_len[k] = free_len[k-1];
            end
            free_start[p] = base;
            free_len[p] = ln;
            free_cnt++;
        end
        blk_live[b] = 0;
        return o;
    endfunction

    function automatic req_t mk_alloc(int unsigned sz);
        req_t r;
        r.req_type = 1'b0;
        r.alloc_size = 12'(sz);
        r.free_addr = 12'($urandom);
        return r;
    endfunction

    function automatic req_t mk_free(int unsigned a);
        req_t r;
        r.req_type = 1'b1;
        r.alloc_size = 12'($urandom);
        r.free_addr = 12'(a);
        return r;
    endfunction

    // Pick a previously handed-out address (may already be freed), or a random one if none yet
    function automatic int unsigned pick_addr();
        if (handed_out.size() == 0) return $urandom_range(4095);
        return handed_out[$urandom_range(handed_out.size() - 1)];
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(pool_predict(req));
                if (expected_rsps[$].status == ST_OK && req.req_type == 1'b0)
                    handed_out.push_back(expected_rsps[$].data_addr);
            end
            if ((req_valid && !req_ready))
                ;
            else if (pending_reqs.size() > 0 && !send_pause &&
                     (idle_off || $urandom_range(99) >= 10))
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response monitor and checker
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response status=%0d data_addr=%0d",
                           rsp.status, rsp.data_addr);
                    errors++;
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
                        errors++;
                    end
                    if (rsp.data_addr !== exp_rsp.data_addr)
                    begin
                        $error("data_addr: expected %0d, got %0d",
                               exp_rsp.data_addr, rsp.data_addr);
                        errors++;
                    end
                end
            end
            rsp_ready <= !hold_rsp && (idle_off || $urandom_range(99) >= 10);
        end
    end

    // Receiver hold-off, counted here in cycles
    initial
    begin
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        hold_rsp = 1;
        repeat (400) @(posedge clk);
        hold_rsp = 0;
    end

    // Stimulus
    initial
    begin
        int unsigned mode;
        pool_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, bad frees, zero size, whole-segment take, full pool
        pending_reqs.push_back(mk_free(0));
        pending_reqs.push_back(mk_free(4095));
        pending_reqs.push_back(mk_alloc(4095));
        pending_reqs.push_back(mk_alloc(0));
        pending_reqs.push_back(mk_alloc(1));
        pending_reqs.push_back(mk_alloc(100));
        pending_reqs.push_back(mk_free(HEADER_BYTES));
        pending_reqs.push_back(mk_free(HEADER_BYTES));
        pending_reqs.push_back(mk_free(2 * HEADER_BYTES + 1));
        pending_reqs.push_back(mk_alloc(POOL_BYTES - 2 * HEADER_BYTES - 200));
        pending_reqs.push_back(mk_alloc(0));
        pending_reqs.push_back(mk_alloc(2048));
        for (int i = 0; i < 12; i++) pending_reqs.push_back(mk_free(24 + 24 * i));
        wait (pending_reqs.size() == 0);

        // Pause the sender until every response has come back
        send_pause = 1;
        wait (!req_valid && expected_rsps.size() == 0);
        send_pause = 0;

        // Random: mostly small allocations and frees of real addresses, to fill
        // both tables; sometimes a long stretch with no idling
        for (int n = 0; n < 1200; n++)
        begin
            if (n == 300) idle_off = 1;
            if (n == 500) idle_off = 0;
            mode = $urandom_range(99);
            if (mode < 40)
                pending_reqs.push_back(mk_alloc($urandom_range(48)));
            else if (mode < 50)
                pending_reqs.push_back(mk_alloc($urandom_range(4095)));
            else if (mode < 90)
                pending_reqs.push_back(mk_free(pick_addr()));
            else
                pending_reqs.push_back(mk_free($urandom_range(4095)));
            if (pending_reqs.size() > 20) wait (pending_reqs.size() < 10);
        end
        wait (pending_reqs.size() == 0 && !req_valid);
        wait (expected_rsps.size() == 0);
        repeat (1000) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
